### rtl/rgb565_tile_blackness_analyzer_core_macros.svh
// ----------------------------------------------------------------------------
// rgb565 tile blackness analyzer assertion macros
// shared concurrent assertion forms, sampled on the rising clock edge
// ----------------------------------------------------------------------------
`ifndef RGB565_TILE_BLACKNESS_ANALYZER_CORE_MACROS_SVH
`define RGB565_TILE_BLACKNESS_ANALYZER_CORE_MACROS_SVH

// same-cycle implication, off while reset is low
`define RTBAL_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rtbal assertion failed");

// next-cycle implication, off while reset is low
`define RTBAL_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rtbal assertion failed");

`endif

### rtl/rtbal_pkg.sv
// ----------------------------------------------------------------------------
// rtbal_pkg
// types, constants and helpers of the rgb565 tile blackness analyzer
// ----------------------------------------------------------------------------
package rtbal_pkg;

    localparam int MAX_TILE_PIXELS   = 65536;
    localparam int QUEUE_DEPTH_DEF   = 4;
    localparam int CNT_W             = 17;
    localparam int CFG_DATA_W        = 17;
    localparam int CFG_IDX_W         = 3;
    localparam int LUM_W             = 9;

    localparam int CNT_LIMIT_INT = (MAX_TILE_PIXELS < 131071) ? MAX_TILE_PIXELS : 131071;
    localparam logic [CNT_W-1:0] CNT_LIMIT   = CNT_W'(CNT_LIMIT_INT);
    localparam logic [31:0]      HASH_PRIME  = 32'd16777619;
    localparam logic [6:0]       PCT_SCALE   = 7'd100;

    localparam logic [12:0] RST_TILE_WIDTH    = 13'd16;
    localparam logic [15:0] RST_ROW_STRIDE    = 16'd16;
    localparam logic [8:0]  RST_BLACK_LEVEL   = 9'd8;
    localparam logic [6:0]  RST_BLACK_PERCENT = 7'd88;
    localparam logic [16:0] RST_MIN_SAMPLES   = 17'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TILE_WIDTH    = 3'd0,
        CFG_ROW_STRIDE    = 3'd1,
        CFG_BLACK_LEVEL   = 3'd2,
        CFG_BLACK_PERCENT = 3'd3,
        CFG_MIN_SAMPLES   = 3'd4
    } t_cfg_idx;

    // settings the back end needs when a tile closes
    typedef struct packed {
        logic [12:0] tile_width;
        logic [15:0] row_stride;
        logic [6:0]  black_percent;
        logic [16:0] min_samples;
    } t_cfg;

    // one classified pixel in the queue
    typedef struct packed {
        logic [15:0]      pixel;
        logic [LUM_W-1:0] lum;
        logic             dark;
        logic             last_pixel;
        logic             tile_shown;
    } t_work;

    function automatic logic [LUM_W-1:0] lum_of(input logic [15:0] px);
        logic [4:0] r;
        logic [5:0] g;
        logic [4:0] b;
        r = px[15:11];
        g = px[10:5];
        b = px[4:0];
        return LUM_W'({r, 1'b0}) + LUM_W'(g) + LUM_W'({g, 1'b0}) + LUM_W'(b);
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v < CNT_LIMIT) ? v + CNT_W'(1) : CNT_LIMIT;
    endfunction

endpackage

### rtl/rtbal_front.sv
// ----------------------------------------------------------------------------
// rtbal_front
// settings registers, pixel intake and near-black classification
// ----------------------------------------------------------------------------
module rtbal_front import rtbal_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [15:0]           i_pixel,
    input  logic                  i_last_pixel,
    input  logic                  i_tile_shown,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_full,
    output logic                  o_push,
    output t_work                 o_push_data,
    output t_cfg                  o_cfg
);

    logic [12:0] r_tile_width;
    logic [15:0] r_row_stride;
    logic [8:0]  r_black_level;
    logic [6:0]  r_black_percent;
    logic [16:0] r_min_samples;
    logic [LUM_W-1:0] lum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_width    <= RST_TILE_WIDTH;
            r_row_stride    <= RST_ROW_STRIDE;
            r_black_level   <= RST_BLACK_LEVEL;
            r_black_percent <= RST_BLACK_PERCENT;
            r_min_samples   <= RST_MIN_SAMPLES;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TILE_WIDTH:    r_tile_width    <= i_cfg_data[12:0];
                CFG_ROW_STRIDE:    r_row_stride    <= i_cfg_data[15:0];
                CFG_BLACK_LEVEL:   r_black_level   <= i_cfg_data[8:0];
                CFG_BLACK_PERCENT: r_black_percent <= i_cfg_data[6:0];
                CFG_MIN_SAMPLES:   r_min_samples   <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    assign lum     = lum_of(i_pixel);
    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_push_data.pixel      = i_pixel;
        o_push_data.lum        = lum;
        o_push_data.dark       = (lum <= r_black_level);
        o_push_data.last_pixel = i_last_pixel;
        o_push_data.tile_shown = i_tile_shown;
    end

    always_comb begin
        o_cfg.tile_width    = r_tile_width;
        o_cfg.row_stride    = r_row_stride;
        o_cfg.black_percent = r_black_percent;
        o_cfg.min_samples   = r_min_samples;
    end

endmodule

### rtl/rtbal_queue.sv
// ----------------------------------------------------------------------------
// rtbal_queue
// small fifo of classified pixels between front and back
// ----------------------------------------------------------------------------
module rtbal_queue import rtbal_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_work i_push_data,
    output logic  o_full,
    output logic  o_valid,
    output t_work o_data,
    input  logic  i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);

    t_work              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_QW-1:0]  r_count;
    logic               do_pop;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_full  = (r_count == CNT_QW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + CNT_QW'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - CNT_QW'(1);
            end
        end
    end

endmodule

### rtl/rtbal_back.sv
// ----------------------------------------------------------------------------
// rtbal_back
// tile accumulators, fingerprint hash and the result register
// ----------------------------------------------------------------------------
module rtbal_back import rtbal_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_work             i_q_data,
    output logic              o_pop,
    input  t_cfg              i_cfg,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [31:0]       o_luminance_total,
    output logic [CNT_W-1:0]  o_dark_count,
    output logic [CNT_W-1:0]  o_pixel_count,
    output logic [31:0]       o_fingerprint,
    output logic              o_suspicious
);

    logic [31:0]      r_lum;
    logic [CNT_W-1:0] r_dark;
    logic [CNT_W-1:0] r_cnt;
    logic [31:0]      r_hash;
    logic             r_out_valid;
    logic [31:0]      r_out_lum;
    logic [CNT_W-1:0] r_out_dark;
    logic [CNT_W-1:0] r_out_cnt;
    logic [31:0]      r_out_hash;
    logic             r_out_sus;

    logic [31:0]      n_lum;
    logic [CNT_W-1:0] n_dark;
    logic [CNT_W-1:0] n_cnt;
    logic [31:0]      n_hash;
    logic [31:0]      hash_x;
    logic [23:0]      dark_scaled;
    logic [23:0]      cnt_scaled;
    logic             sus;
    logic             stride_bad;
    logic             out_free;

    // a closing pixel waits for the result register; others flow on
    assign out_free = !r_out_valid || i_ready;
    assign o_pop    = i_q_valid && (!i_q_data.last_pixel || out_free);

    always_comb begin
        n_lum       = r_lum + 32'(i_q_data.lum);
        n_dark      = i_q_data.dark ? sat_inc(r_dark) : r_dark;
        n_cnt       = sat_inc(r_cnt);
        hash_x      = r_hash ^ 32'(i_q_data.pixel);
        n_hash      = hash_x * HASH_PRIME;
        dark_scaled = 24'(n_dark) * 24'(PCT_SCALE);
        cnt_scaled  = 24'(n_cnt) * 24'(i_cfg.black_percent);
        sus         = i_q_data.tile_shown && (n_cnt >= i_cfg.min_samples)
                      && (dark_scaled >= cnt_scaled);
        stride_bad  = (i_cfg.row_stride < 16'(i_cfg.tile_width));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lum       <= '0;
            r_dark      <= '0;
            r_cnt       <= '0;
            r_hash      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop && i_q_data.last_pixel) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                if (i_q_data.last_pixel) begin
                    r_lum  <= '0;
                    r_dark <= '0;
                    r_cnt  <= '0;
                    r_hash <= '0;
                end else begin
                    r_lum  <= n_lum;
                    r_dark <= n_dark;
                    r_cnt  <= n_cnt;
                    r_hash <= n_hash;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_q_data.last_pixel) begin
            if (stride_bad) begin
                r_out_lum  <= '0;
                r_out_dark <= '0;
                r_out_cnt  <= '0;
                r_out_hash <= '0;
                r_out_sus  <= 1'b0;
            end else begin
                r_out_lum  <= n_lum;
                r_out_dark <= n_dark;
                r_out_cnt  <= n_cnt;
                r_out_hash <= n_hash;
                r_out_sus  <= sus;
            end
        end
    end

    assign o_valid           = r_out_valid;
    assign o_luminance_total = r_out_lum;
    assign o_dark_count      = r_out_dark;
    assign o_pixel_count     = r_out_cnt;
    assign o_fingerprint     = r_out_hash;
    assign o_suspicious      = r_out_sus;

endmodule

### rtl/rgb565_tile_blackness_analyzer_core.sv
// ----------------------------------------------------------------------------
// rgb565_tile_blackness_analyzer_core
// per-tile luminance sum, near-black count, pixel count and fingerprint
// ----------------------------------------------------------------------------
// throughput: one pixel per cycle, but a closing pixel waits while the result register is full
// a last pixel passes through the pixel queue into the result register, which drives o_valid
// the pixel queue (QUEUE_DEPTH entries) absorbs output stalls
// reset: synchronous active low; settings return to defaults, sums clear
module rgb565_tile_blackness_analyzer_core import rtbal_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [15:0]           i_pixel,
    input  logic                  i_last_pixel,
    input  logic                  i_tile_shown,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [31:0]           o_luminance_total,
    output logic [CNT_W-1:0]      o_dark_count,
    output logic [CNT_W-1:0]      o_pixel_count,
    output logic [31:0]           o_fingerprint,
    output logic                  o_suspicious,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic  q_full;
    logic  q_push;
    t_work q_push_data;
    logic  q_valid;
    t_work q_data;
    logic  q_pop;
    t_cfg  cfg;

    rtbal_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_pixel      (i_pixel),
        .i_last_pixel (i_last_pixel),
        .i_tile_shown (i_tile_shown),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_full       (q_full),
        .o_push       (q_push),
        .o_push_data  (q_push_data),
        .o_cfg        (cfg)
    );

    rtbal_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .o_full      (q_full),
        .o_valid     (q_valid),
        .o_data      (q_data),
        .i_pop       (q_pop)
    );

    rtbal_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (q_valid),
        .i_q_data          (q_data),
        .o_pop             (q_pop),
        .i_cfg             (cfg),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_luminance_total (o_luminance_total),
        .o_dark_count      (o_dark_count),
        .o_pixel_count     (o_pixel_count),
        .o_fingerprint     (o_fingerprint),
        .o_suspicious      (o_suspicious)
    );

endmodule

### rtl/rtbal_checker.sv
// ----------------------------------------------------------------------------
// rtbal_checker
// port-level checks of the tile blackness analyzer result channel
// ----------------------------------------------------------------------------
`include "rgb565_tile_blackness_analyzer_core_macros.svh"

module rtbal_checker import rtbal_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_valid,
    input logic             i_ready,
    input logic [31:0]      o_luminance_total,
    input logic [CNT_W-1:0] o_dark_count,
    input logic [CNT_W-1:0] o_pixel_count,
    input logic [31:0]      o_fingerprint,
    input logic             o_suspicious
);

    logic                  out_wait;
    logic [64+2*CNT_W:0]   out_bus;
    logic                  zero_fields;

    assign out_wait    = o_valid && !i_ready;
    assign out_bus     = {o_luminance_total, o_dark_count, o_pixel_count, o_fingerprint,
                          o_suspicious};
    assign zero_fields = (o_luminance_total == '0) && (o_fingerprint == '0)
                         && (o_dark_count == '0) && !o_suspicious;

    `RTBAL_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_wait, o_valid)
    `RTBAL_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, out_wait, $stable(out_bus))
    // dark pixels are a subset of all pixels, both saturate at the same limit
    `RTBAL_ASSERT_IMP(a_dark_le_count, i_clk, i_rst_n, o_valid, o_dark_count <= o_pixel_count)
    // a zero pixel count only comes from the stride check, which zeroes everything
    `RTBAL_ASSERT_IMP(a_zero_result, i_clk, i_rst_n, o_valid && (o_pixel_count == '0), zero_fields)

endmodule

bind rgb565_tile_blackness_analyzer_core rtbal_checker u_rtbal_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_luminance_total (o_luminance_total),
    .o_dark_count      (o_dark_count),
    .o_pixel_count     (o_pixel_count),
    .o_fingerprint     (o_fingerprint),
    .o_suspicious      (o_suspicious)
);

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: rgb565 tile blackness analyzer regression
// drives pixel tiles through the valid/ready port, predicts each tile result
// in step with the accepted pixels and checks every result as it leaves,
// under several register settings and sender/receiver idling mixes
// ----------------------------------------------------------------------------
module tb import rtbal_pkg::*; ();

    localparam int SETTLE_CYCLES   = 16;
    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam int SEGMENTS        = 16;
    localparam int SEG_PIXELS      = 40;
    localparam int DIRECTED_ROWS   = 27;

    typedef struct packed {
        logic [31:0]      lum_total;
        logic [CNT_W-1:0] dark_count;
        logic [CNT_W-1:0] pixel_count;
        logic [31:0]      fingerprint;
        logic             suspicious;
    } t_tile_stats;

    typedef enum logic {ROW_PIXEL, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        t_cfg_idx              reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic [15:0]           pixel;
        logic                  last;
        logic                  vis;
        logic                  fixed;
        t_tile_stats           stats;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [15:0]           i_pixel = '0;
    logic                  i_last_pixel = 1'b0;
    logic                  i_tile_shown = 1'b0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [31:0]           o_luminance_total;
    logic [CNT_W-1:0]      o_dark_count;
    logic [CNT_W-1:0]      o_pixel_count;
    logic [31:0]           o_fingerprint;
    logic                  o_suspicious;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // typed-in expectation travels with the pixel that closes the tile
    logic        fixed_en = 1'b0;
    t_tile_stats fixed_stats = '0;

    int idle_pct = 0;
    int stall_pct = 0;
    int cycle_cnt = 0;
    int mismatch_cnt = 0;

    // predictor settings and tile accumulators
    logic [12:0] m_tile_width = RST_TILE_WIDTH;
    logic [15:0] m_row_stride = RST_ROW_STRIDE;
    logic [8:0]  m_black_level = RST_BLACK_LEVEL;
    logic [6:0]  m_black_percent = RST_BLACK_PERCENT;
    logic [16:0] m_min_samples = RST_MIN_SAMPLES;
    logic [31:0]      acc_lum = '0;
    logic [CNT_W-1:0] acc_dark = '0;
    logic [CNT_W-1:0] acc_pix = '0;
    logic [31:0]      acc_hash = '0;

    t_tile_stats pending_tiles[$];
    t_stim_row   directed_rows[DIRECTED_ROWS];

    rgb565_tile_blackness_analyzer_core dut (.*);

    always #1 i_clk = ~i_clk;

    function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] v);
        return (v < CNT_LIMIT) ? v + CNT_W'(1) : CNT_LIMIT;
    endfunction

    function automatic void apply_setting(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
        case (t_cfg_idx'(idx))
            CFG_TILE_WIDTH:    m_tile_width = val[12:0];
            CFG_ROW_STRIDE:    m_row_stride = val[15:0];
            CFG_BLACK_LEVEL:   m_black_level = val[8:0];
            CFG_BLACK_PERCENT: m_black_percent = val[6:0];
            CFG_MIN_SAMPLES:   m_min_samples = val[16:0];
            default: ;
        endcase
    endfunction

    // folds one pixel into the tile; returns 1 with the tile stats on the last pixel
    function automatic bit fold_pixel(input logic [15:0] px, input logic last,
                                      input logic vis, output t_tile_stats res);
        int unsigned lum;
        longint unsigned dark_scaled;
        longint unsigned pix_scaled;
        lum = 2 * int'(px[15:11]) + 3 * int'(px[10:5]) + int'(px[4:0]);
        acc_lum = acc_lum + lum;
        if (lum <= m_black_level)
            acc_dark = count_up(acc_dark);
        acc_hash = (acc_hash ^ {16'h0000, px}) * HASH_PRIME;
        acc_pix = count_up(acc_pix);
        res = '0;
        if (!last)
            return 1'b0;
        if (m_row_stride >= {3'b000, m_tile_width}) begin
            dark_scaled = longint'(acc_dark) * 100;
            pix_scaled = longint'(acc_pix) * longint'(m_black_percent);
            res.lum_total = acc_lum;
            res.dark_count = acc_dark;
            res.pixel_count = acc_pix;
            res.fingerprint = acc_hash;
            res.suspicious = vis && (acc_pix >= m_min_samples) && (dark_scaled >= pix_scaled);
        end
        acc_lum = '0;
        acc_dark = '0;
        acc_pix = '0;
        acc_hash = '0;
        return 1'b1;
    endfunction

    function automatic t_stim_row pix_row(input logic [15:0] px, input logic last,
                                          input logic vis, input logic fixed = 1'b0,
                                          input t_tile_stats stats = '0);
        t_stim_row r;
        r = '0;
        r.kind = ROW_PIXEL;
        r.pixel = px;
        r.last = last;
        r.vis = vis;
        r.fixed = fixed;
        r.stats = stats;
        return r;
    endfunction

    function automatic t_stim_row reg_row(input t_cfg_idx idx, input int unsigned val);
        t_stim_row r;
        r = '0;
        r.kind = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = CFG_DATA_W'(val);
        return r;
    endfunction

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d tiles pending", cycle_cnt,
                     pending_tiles.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin : monitor
        t_tile_stats predicted;
        t_tile_stats got;
        t_tile_stats want;
        if (i_rst_n) begin
            if (i_cfg_we)
                apply_setting(i_cfg_index, i_cfg_data);
            if (i_valid && o_ready &&
                fold_pixel(i_pixel, i_last_pixel, i_tile_shown, predicted))
                pending_tiles.push_back(fixed_en ? fixed_stats : predicted);
            if (o_valid && i_ready) begin
                got = '{o_luminance_total, o_dark_count, o_pixel_count, o_fingerprint,
                        o_suspicious};
                if (pending_tiles.size() == 0) begin
                    if (mismatch_cnt < 10)
                        $display("cycle %0d: tile result with none pending: lum %h dark %0d",
                                 cycle_cnt, got.lum_total, got.dark_count);
                    mismatch_cnt++;
                end else begin
                    want = pending_tiles.pop_front();
                    if (got !== want) begin
                        if (mismatch_cnt < 10) begin
                            $display("cycle %0d: tile result mismatch", cycle_cnt);
                            $display("  expected lum %h dark %0d pix %0d fp %h sus %b",
                                     want.lum_total, want.dark_count, want.pixel_count,
                                     want.fingerprint, want.suspicious);
                            $display("  actual   lum %h dark %0d pix %0d fp %h sus %b",
                                     got.lum_total, got.dark_count, got.pixel_count,
                                     got.fingerprint, got.suspicious);
                        end
                        mismatch_cnt++;
                    end
                end
            end
        end
    end

    // called at a rising edge; returns at the edge where the item is taken
    task automatic send_pixel(input logic [15:0] px, input logic last, input logic vis,
                              input logic fixed, input t_tile_stats stats);
        logic took;
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= px;
        i_last_pixel <= last;
        i_tile_shown <= vis;
        fixed_en <= fixed;
        fixed_stats <= stats;
        do begin
            @(negedge i_clk);
            took = o_ready;
            @(posedge i_clk);
        end while (!took);
    endtask

    task automatic wait_drain();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending_tiles.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic program_settings(input int unsigned width, input int unsigned stride,
                                    input int unsigned level, input int unsigned pct,
                                    input int unsigned min_px);
        wait_drain();
        reg_write(CFG_TILE_WIDTH, CFG_DATA_W'(width));
        reg_write(CFG_ROW_STRIDE, CFG_DATA_W'(stride));
        reg_write(CFG_BLACK_LEVEL, CFG_DATA_W'(level));
        reg_write(CFG_BLACK_PERCENT, CFG_DATA_W'(pct));
        reg_write(CFG_MIN_SAMPLES, CFG_DATA_W'(min_px));
        i_cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        bit          reg_open;
        int unsigned width;
        int unsigned stride;
        int unsigned level;
        int unsigned pct;
        int unsigned min_px;
        int          sent;
        int          tile_len;
        int          dark_p;
        logic [15:0] px;

        directed_rows = '{
            pix_row(16'h0000, 1'b1, 1'b1, 1'b1, t_tile_stats'{32'd0, 17'd1, 17'd1, 32'd0, 1'b0}),
            pix_row(16'hFFFF, 1'b1, 1'b1),
            pix_row(16'hF800, 1'b0, 1'b0),
            pix_row(16'h07E0, 1'b0, 1'b1),
            pix_row(16'h001F, 1'b0, 1'b0),
            pix_row(16'h0008, 1'b1, 1'b1),
            pix_row(16'h0009, 1'b1, 1'b1),
            reg_row(CFG_MIN_SAMPLES, 0),
            reg_row(CFG_BLACK_PERCENT, 0),
            pix_row(16'hFFFF, 1'b1, 1'b1),
            pix_row(16'hFFFF, 1'b1, 1'b0),
            // percent above 100 never trips
            reg_row(CFG_BLACK_PERCENT, 127),
            pix_row(16'h0000, 1'b1, 1'b1),
            reg_row(CFG_BLACK_PERCENT, 100),
            pix_row(16'h0000, 1'b0, 1'b1),
            pix_row(16'h0000, 1'b1, 1'b1),
            // stride below width zeroes the whole result
            reg_row(CFG_ROW_STRIDE, 0),
            pix_row(16'h1234, 1'b0, 1'b1),
            pix_row(16'hABCD, 1'b1, 1'b1, 1'b1, '0),
            reg_row(CFG_TILE_WIDTH, 4096),
            reg_row(CFG_ROW_STRIDE, 4095),
            pix_row(16'h5555, 1'b1, 1'b1, 1'b1, '0),
            reg_row(CFG_ROW_STRIDE, 4096),
            reg_row(CFG_BLACK_LEVEL, 282),
            reg_row(CFG_MIN_SAMPLES, 65536),
            pix_row(16'hAAAA, 1'b0, 1'b1),
            pix_row(16'hFFFF, 1'b1, 1'b1)
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        reg_open = 1'b0;
        foreach (directed_rows[k]) begin
            if (directed_rows[k].kind == ROW_REG) begin
                if (!reg_open)
                    wait_drain();
                reg_write(directed_rows[k].reg_idx, directed_rows[k].reg_val);
                reg_open = 1'b1;
            end else begin
                if (reg_open) begin
                    i_cfg_we <= 1'b0;
                    reg_open = 1'b0;
                end
                send_pixel(directed_rows[k].pixel, directed_rows[k].last,
                           directed_rows[k].vis, directed_rows[k].fixed,
                           directed_rows[k].stats);
            end
        end

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 85; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 85; end
                default: begin idle_pct = 26; stall_pct = 26; end
            endcase
            case ($urandom_range(3))
                0: width = 1;
                1: width = 4096;
                2: width = $urandom_range(4096, 1);
                default: width = $urandom_range(64, 1);
            endcase
            case ($urandom_range(9))
                0: stride = $urandom_range(width - 1, 0);
                1: stride = 65535;
                default: stride = width + $urandom_range(64);
            endcase
            case ($urandom_range(3))
                0: level = 0;
                1: level = 282;
                2: level = $urandom_range(282);
                default: level = $urandom_range(40);
            endcase
            case ($urandom_range(4))
                0: pct = 0;
                1: pct = 100;
                2: pct = $urandom_range(100);
                3: pct = $urandom_range(100, 60);
                default: pct = $urandom_range(127, 101);
            endcase
            case ($urandom_range(4))
                0: min_px = 0;
                1: min_px = 65536;
                default: min_px = $urandom_range(20);
            endcase
            program_settings(width, stride, level, pct, min_px);

            sent = 0;
            while (sent < SEG_PIXELS) begin
                tile_len = ($urandom_range(4) != 0) ? $urandom_range(16, 1)
                                                    : $urandom_range(40, 17);
                dark_p = $urandom_range(100);
                for (int n = 1; n <= tile_len; n++) begin
                    // dark pixels keep every channel tiny
                    if ($urandom_range(99) < dark_p)
                        px = {3'b000, 2'($urandom_range(3)), 4'b0000, 2'($urandom_range(3)),
                              3'b000, 2'($urandom_range(3))};
                    else
                        px = 16'($urandom);
                    send_pixel(px, n == tile_len, $urandom_range(3) != 0, 1'b0, '0);
                end
                sent += tile_len;
            end
        end

        wait_drain();
        if (mismatch_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### rgb565_tile_blackness_analyzer_core.f
+incdir+rtl
rtl/rtbal_pkg.sv
rtl/rtbal_front.sv
rtl/rtbal_queue.sv
rtl/rtbal_back.sv
rtl/rgb565_tile_blackness_analyzer_core.sv
rtl/rtbal_checker.sv
tb/sv/tb.sv
